@@ rtl/plt_pkg.sv @@
package plt_pkg;

  localparam int CAPACITY    = 32;
  localparam int ENTRY_WIDTH = 32;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

  typedef logic [ENTRY_WIDTH-1:0] entry_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CMP_W-1:0]       cmp_t;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_GET    = 3'd2,
    KIND_LOCATE = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] read_value;
    logic [5:0]         found_position;
    logic [5:0]         entry_count_out;
  } out_item_t;

  // control broadcast from the table's request decode to every cell
  typedef struct packed {
    logic   ins;
    logic   del;
    cmp_t   pos0;
    cmp_t   count;
    entry_t val;
  } cell_ctl_t;

endpackage

@@ rtl/plt_cell.sv @@
module plt_cell (
  input  logic              clk,
  input  plt_pkg::cell_ctl_t ctl,
  input  plt_pkg::idx_t     idx,
  input  plt_pkg::entry_t   left_q,
  input  plt_pkg::entry_t   right_q,
  output plt_pkg::entry_t   q,
  output logic              hit,
  output logic              match
);

  plt_pkg::entry_t q_r;
  plt_pkg::entry_t q_nxt;
  plt_pkg::cmp_t   my_idx;

  assign my_idx = plt_pkg::cmp_t'(idx);

  always_comb begin
    q_nxt = q_r;
    if (ctl.ins) begin
      if (my_idx > ctl.pos0) begin
        q_nxt = left_q;
      end else if (my_idx == ctl.pos0) begin
        q_nxt = ctl.val;
      end
    end else if (ctl.del) begin
      // the last cell takes its own value, which then lies beyond the count
      if (my_idx >= ctl.pos0) begin
        q_nxt = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q     = q_r;
  assign hit   = (my_idx == ctl.pos0);
  assign match = (my_idx < ctl.count) && (q_r == ctl.val);

endmodule

@@ rtl/positional_list_table.sv @@
// the result item is registered at the accepting edge and offered in the next cycle
// one item per cycle while in_stall is low; each cell shifts, stores and compares its entry
// in parallel, so every request is done at its update edge
// in_stall is high only while a finished result waits behind out_stall
// reset clears the entry count and the result valid; entry contents stay undefined
module positional_list_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  plt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output plt_pkg::out_item_t out_item
);

  // list state
  plt_pkg::count_t count_r;
  plt_pkg::count_t count_nxt;

  // result register
  logic               out_valid_r;
  logic               out_valid_nxt;
  plt_pkg::out_item_t out_item_r;
  plt_pkg::out_item_t out_item_nxt;

  logic              accept;
  plt_pkg::cmp_t     pos_w;
  plt_pkg::cmp_t     cnt_w;
  plt_pkg::entry_t   in_entry;
  logic              pos_ok_rd;   // position names an existing entry
  logic              pos_ok_ins;  // position lies within 1 .. count + 1
  logic              not_full;
  plt_pkg::cell_ctl_t ctl;

  // cell row
  plt_pkg::entry_t     cell_q   [plt_pkg::CAPACITY];
  logic [plt_pkg::CAPACITY-1:0] cell_hit;
  logic [plt_pkg::CAPACITY-1:0] cell_match;

  plt_pkg::entry_t   get_entry;
  plt_pkg::cmp_t     found_idx;
  logic [63:0]       wide_in;
  logic [63:0]       wide_rd;

  // accept whenever the result register is free or being drained
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign pos_w    = plt_pkg::cmp_t'(in_item.position);
  assign cnt_w    = plt_pkg::cmp_t'(count_r);
  assign wide_in  = 64'(unsigned'(in_item.value));
  assign in_entry = wide_in[plt_pkg::ENTRY_WIDTH-1:0];

  assign pos_ok_rd  = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + plt_pkg::cmp_t'(1));
  assign not_full   = (cnt_w < plt_pkg::cmp_t'(plt_pkg::CAPACITY));

  // broadcast to the row; shifts only when the request is legal
  always_comb begin
    ctl       = '0;
    ctl.pos0  = pos_w - plt_pkg::cmp_t'(1);
    ctl.count = cnt_w;
    ctl.val   = in_entry;
    ctl.ins   = accept && (in_item.kind == plt_pkg::KIND_INSERT) && not_full && pos_ok_ins;
    ctl.del   = accept && (in_item.kind == plt_pkg::KIND_DELETE) && pos_ok_rd;
  end

  // row of cells, each handing its entry to both neighbours
  for (genvar g = 0; g < plt_pkg::CAPACITY; g++) begin : g_cell
    plt_pkg::entry_t left_q;
    plt_pkg::entry_t right_q;

    if (g == 0) begin : g_first
      assign left_q = in_entry;
    end else begin : g_mid_l
      assign left_q = cell_q[g-1];
    end

    if (g == plt_pkg::CAPACITY - 1) begin : g_last
      assign right_q = cell_q[g];
    end else begin : g_mid_r
      assign right_q = cell_q[g+1];
    end

    plt_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (plt_pkg::idx_t'(g)),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[g]),
      .hit     (cell_hit[g]),
      .match   (cell_match[g])
    );
  end

  // read path: and-or of the one cell whose index matches the position
  always_comb begin
    get_entry = '0;
    for (int i = 0; i < plt_pkg::CAPACITY; i++) begin
      get_entry = get_entry | (cell_q[i] & {plt_pkg::ENTRY_WIDTH{cell_hit[i]}});
    end
  end

  // first match wins: scan from the top so the lowest index is kept
  always_comb begin
    found_idx = '0;
    for (int i = plt_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        found_idx = plt_pkg::cmp_t'(i + 1);
      end
    end
  end

  assign wide_rd = 64'(get_entry);

  // request decode and next count
  always_comb begin
    count_nxt    = count_r;
    out_item_nxt = '0;
    out_item_nxt.status = 1'b1;
    unique case (in_item.kind)
      plt_pkg::KIND_INSERT: begin
        if (not_full && pos_ok_ins) begin
          out_item_nxt.status = 1'b0;
          count_nxt = count_r + plt_pkg::count_t'(1);
        end
      end
      plt_pkg::KIND_DELETE: begin
        if (pos_ok_rd) begin
          out_item_nxt.status     = 1'b0;
          out_item_nxt.read_value = wide_rd[31:0];
          count_nxt = count_r - plt_pkg::count_t'(1);
        end
      end
      plt_pkg::KIND_GET: begin
        if (pos_ok_rd) begin
          out_item_nxt.status     = 1'b0;
          out_item_nxt.read_value = wide_rd[31:0];
        end
      end
      plt_pkg::KIND_LOCATE: begin
        out_item_nxt.status         = 1'b0;
        out_item_nxt.found_position = found_idx[5:0];
      end
      plt_pkg::KIND_CLEAR: begin
        if (count_r != '0) begin
          out_item_nxt.status = 1'b0;
          count_nxt = '0;
        end
      end
      default: begin
        out_item_nxt.status = 1'b1;
      end
    endcase
    out_item_nxt.entry_count_out = 6'(count_nxt);
    if (!accept) begin
      count_nxt = count_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    plt_pkg::cmp_t'(count_r) <= plt_pkg::cmp_t'(plt_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_accept_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item left no result");

  a_no_shift_both : assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.ins && ctl.del))
    else $error("insert and delete shift together");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> count_r == $past(count_r))
    else $error("entry count moved without a request");

  a_err_no_data : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status) |-> (out_item_r.read_value == '0))
    else $error("error result carries data");
`endif

endmodule
